[rtl/core/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, codes and constants of the Modbus RTU reply checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    // default receive buffer depth
    localparam int RX_BYTES_DEF = 64;

    // largest number of register words one read reply may give
    localparam int MAX_WORDS = 29;

    // payload widths on the stream channels
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 112;

    // input item kinds (tuser of the slave side)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // result kinds (tuser of the master side)
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_WORD    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // frame verdicts
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT     = 4'd1;
    localparam logic [3:0] ST_CRC       = 4'd2;
    localparam logic [3:0] ST_DEVICE    = 4'd3;
    localparam logic [3:0] ST_FUNCTION  = 4'd4;
    localparam logic [3:0] ST_EXCEPTION = 4'd5;
    localparam logic [3:0] ST_COUNT     = 4'd6;
    localparam logic [3:0] ST_ECHO      = 4'd7;
    localparam logic [3:0] ST_UNHANDLED = 4'd8;

    // function codes handled
    localparam logic [6:0] FN_READ_HOLD  = 7'd3;
    localparam logic [6:0] FN_READ_INPUT = 7'd4;
    localparam logic [6:0] FN_WRITE_ONE  = 7'd6;
    localparam logic [6:0] FN_WRITE_MANY = 7'd16;

    // configuration register indexes
    localparam logic CFG_REPLY_TIMEOUT = 1'b0;
    localparam logic CFG_FRAME_GAP     = 1'b1;

    // reset values of the configuration registers
    localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd500;
    localparam logic [7:0]  FRAME_GAP_RST     = 8'd10;

    // crc-16 constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // write-multiple counts at or above this limit are refused
    localparam logic [6:0] WRITE_MANY_LIMIT = 7'd120;

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CRC   = 8'b0000_0010,
        S_JUDGE = 8'b0000_0100,
        S_HDR   = 8'b0000_1000,
        S_EVAL  = 8'b0001_0000,
        S_WORD  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_TMO   = 8'b1000_0000
    } state_t;

    // control of the shared crc unit
    typedef struct packed {
        logic       clear;
        logic       mix;
        logic       step;
        logic [7:0] data;
    } crc_ctrl_t;

endpackage

[rtl/core/modbus_rtu_master_reply_checker_core.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_master_reply_checker_core
// Tracks one outstanding Modbus RTU request and judges the reply frame.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ side: tuser carries the op (start request,
// received byte, 1 ms tick), tdata the request fields and the byte. Results
// leave on the m_ side: tuser is the result kind, tlast marks the final
// result of one input item. Configuration is a plain write port; it is to be
// written only while the block is idle; the block does not enforce this.
// Item handling: a start is taken in the idle state. A received byte is
// worked through the bit-serial CRC unit (one shift per cycle). A tick
// without a verdict goes through the reply timer check. Judging a frame
// reads the six header bytes through the single buffer read port before
// the status result, then fetches each register word from the buffer and
// hands it out, and ends with a reply timer check. s_tready is low while
// an item is being worked on.
// When the receiver stalls, the pending result holds on m_tdata and the
// sequencer waits; no input is taken meanwhile.
// Reset clears all counters, timers and the request record; the buffer
// itself is not cleared, as only bytes written for the current frame are used.
// ----------------------------------------------------------------------------
module modbus_rtu_master_reply_checker_core
#(
    parameter int RX_BYTES = mrc_pkg::RX_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // dev_number, fun_code, reg_address, reg_count, reg_value, rx_byte
    input  logic [mrc_pkg::IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic [1:0]                     s_tuser,
    // master side
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, reply_function, exception_code, data_word, word_index,
    // timeout_total, crc_error_total
    output logic [mrc_pkg::OUT_DATA_W-1:0] m_tdata,
    // kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    // configuration
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [15:0]                    cfg_data
);

    localparam int AW = $clog2(RX_BYTES);
    localparam int LW = $clog2(RX_BYTES + 1);

    // input fields
    logic [7:0]  in_dev;
    logic [7:0]  in_fun;
    logic [15:0] in_addr;
    logic [6:0]  in_cnt;
    logic [15:0] in_val;
    logic [7:0]  in_byte;

    assign in_dev  = s_tdata[7:0];
    assign in_fun  = s_tdata[15:8];
    assign in_addr = s_tdata[31:16];
    assign in_cnt  = s_tdata[38:32];
    assign in_val  = s_tdata[54:39];
    assign in_byte = s_tdata[62:55];

    // state
    mrc_pkg::state_t state_reg, state_next;
    logic [15:0] tmo_cfg_reg, tmo_cfg_next;
    logic [7:0]  gap_cfg_reg, gap_cfg_next;
    logic [LW-1:0] len_reg, len_next;
    logic        seen_reg, seen_next;
    logic [7:0]  silence_reg, silence_next;
    logic        pend_reg, pend_next;
    logic [7:0]  exp_dev_reg, exp_dev_next;
    logic [7:0]  exp_fun_reg, exp_fun_next;
    logic [15:0] exp_addr_reg, exp_addr_next;
    logic [6:0]  exp_cnt_reg, exp_cnt_next;
    logic [15:0] exp_val_reg, exp_val_next;
    logic [15:0] age_reg, age_next;
    logic [31:0] tmo_tot_reg, tmo_tot_next;
    logic [31:0] crc_tot_reg, crc_tot_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]  wcnt_reg, wcnt_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [6:0]  nwords_reg, nwords_next;
    logic [6:0]  widx_reg, widx_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  hdr_reg [6];
    logic        hdr_we;
    logic [2:0]  hdr_sel;

    // result register
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [3:0]  out_status_reg, out_status_next;
    logic [6:0]  out_fn_reg, out_fn_next;
    logic [7:0]  out_exc_reg, out_exc_next;
    logic [15:0] out_word_reg, out_word_next;
    logic [6:0]  out_idx_reg, out_idx_next;
    logic        out_last_reg, out_last_next;

    // buffer and crc unit hookup
    mrc_pkg::crc_ctrl_t crc_ctrl;
    logic          crc_zero;
    logic          mem_we;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    mrc_crc_unit u_crc
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (crc_ctrl),
        .crc_zero (crc_zero)
    );

    mrc_rx_mem #(.DEPTH(RX_BYTES)) u_mem
    (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (len_reg[AW-1:0]),
        .wr_data (in_byte),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // header decode for the verdict
    logic [6:0]  fn;
    logic [6:0]  nread;
    logic [15:0] w2;
    logic [15:0] w4;
    logic [9:0]  need_len;
    logic        s_xfer;
    logic        m_xfer;

    assign fn       = hdr_reg[1][6:0];
    assign nread    = hdr_reg[2][7:1];
    assign w2       = {hdr_reg[2], hdr_reg[3]};
    assign w4       = {hdr_reg[4], hdr_reg[5]};
    assign need_len = 10'd5 + {2'd0, nread, 1'b0};
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        tmo_cfg_next    = tmo_cfg_reg;
        gap_cfg_next    = gap_cfg_reg;
        len_next        = len_reg;
        seen_next       = seen_reg;
        silence_next    = silence_reg;
        pend_next       = pend_reg;
        exp_dev_next    = exp_dev_reg;
        exp_fun_next    = exp_fun_reg;
        exp_addr_next   = exp_addr_reg;
        exp_cnt_next    = exp_cnt_reg;
        exp_val_next    = exp_val_reg;
        age_next        = age_reg;
        tmo_tot_next    = tmo_tot_reg;
        crc_tot_next    = crc_tot_reg;
        bit_cnt_next    = bit_cnt_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        wcnt_next       = wcnt_reg;
        ptr_next        = ptr_reg;
        nwords_next     = nwords_reg;
        widx_next       = widx_reg;
        hi_next         = hi_reg;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_fn_next     = out_fn_reg;
        out_exc_next    = out_exc_reg;
        out_word_next   = out_word_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        crc_ctrl        = '0;
        crc_ctrl.data   = in_byte;
        mem_we          = 1'b0;
        mem_rd_addr     = ptr_reg;
        hdr_we          = 1'b0;
        hdr_sel         = hdr_cnt_reg - 3'd1;

        // configuration writes
        if (cfg_we)
        begin
            if (cfg_index == mrc_pkg::CFG_REPLY_TIMEOUT)
            begin
                tmo_cfg_next = cfg_data;
            end
            else
            begin
                gap_cfg_next = cfg_data[7:0];
            end
        end

        case (state_reg)
            mrc_pkg::S_IDLE:
            begin
                if (s_xfer)
                begin
                    case (s_tuser)
                        mrc_pkg::OP_START:
                        begin
                            if (!(in_fun == {1'b0, mrc_pkg::FN_WRITE_MANY}
                                  && in_cnt >= mrc_pkg::WRITE_MANY_LIMIT))
                            begin
                                exp_dev_next   = in_dev;
                                exp_fun_next   = in_fun;
                                exp_addr_next  = in_addr;
                                exp_cnt_next   = in_cnt;
                                exp_val_next   = in_val;
                                pend_next      = 1'b1;
                                age_next       = 16'd0;
                                len_next       = '0;
                                seen_next      = 1'b0;
                                silence_next   = 8'd0;
                                crc_ctrl.clear = 1'b1;
                            end
                        end
                        mrc_pkg::OP_BYTE:
                        begin
                            seen_next    = 1'b1;
                            silence_next = 8'd0;
                            if (len_reg < LW'(RX_BYTES))
                            begin
                                mem_we       = 1'b1;
                                crc_ctrl.mix = 1'b1;
                                len_next     = len_reg + 1'b1;
                                bit_cnt_next = 3'd0;
                                state_next   = mrc_pkg::S_CRC;
                            end
                        end
                        mrc_pkg::OP_TICK:
                        begin
                            if (seen_reg && silence_reg >= gap_cfg_reg)
                            begin
                                state_next = mrc_pkg::S_JUDGE;
                            end
                            else
                            begin
                                if (seen_reg)
                                begin
                                    silence_next = silence_reg + 8'd1;
                                end
                                state_next = mrc_pkg::S_TMO;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // eight shift steps of the crc unit
            mrc_pkg::S_CRC:
            begin
                crc_ctrl.step = 1'b1;
                bit_cnt_next  = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    state_next = mrc_pkg::S_IDLE;
                end
            end

            // length and crc checks
            mrc_pkg::S_JUDGE:
            begin
                out_kind_next = mrc_pkg::KIND_STATUS;
                out_fn_next   = 7'd0;
                out_exc_next  = 8'd0;
                out_word_next = 16'd0;
                out_idx_next  = 7'd0;
                out_last_next = !(pend_reg && age_reg >= tmo_cfg_reg);
                nwords_next   = 7'd0;
                if (len_reg <= LW'(4))
                begin
                    out_status_next = mrc_pkg::ST_SHORT;
                    len_next        = '0;
                    seen_next       = 1'b0;
                    silence_next    = 8'd0;
                    crc_ctrl.clear  = 1'b1;
                    state_next      = mrc_pkg::S_OUT;
                end
                else if (!crc_zero)
                begin
                    out_status_next = mrc_pkg::ST_CRC;
                    crc_tot_next    = crc_tot_reg + 32'd1;
                    len_next        = '0;
                    seen_next       = 1'b0;
                    silence_next    = 8'd0;
                    crc_ctrl.clear  = 1'b1;
                    state_next      = mrc_pkg::S_OUT;
                end
                else
                begin
                    hdr_cnt_next = 3'd0;
                    state_next   = mrc_pkg::S_HDR;
                end
            end

            // read the first six bytes of the frame
            mrc_pkg::S_HDR:
            begin
                mem_rd_addr  = AW'(hdr_cnt_reg);
                hdr_we       = (hdr_cnt_reg != 3'd0);
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                if (hdr_cnt_reg == 3'd6)
                begin
                    state_next = mrc_pkg::S_EVAL;
                end
            end

            // verdict from the header
            mrc_pkg::S_EVAL:
            begin
                out_kind_next = mrc_pkg::KIND_STATUS;
                out_fn_next   = fn;
                out_exc_next  = 8'd0;
                out_word_next = 16'd0;
                out_idx_next  = 7'd0;
                nwords_next   = 7'd0;
                widx_next     = 7'd0;
                ptr_next      = AW'(3);
                len_next      = '0;
                seen_next     = 1'b0;
                silence_next  = 8'd0;
                crc_ctrl.clear = 1'b1;
                state_next    = mrc_pkg::S_OUT;
                if (hdr_reg[0] != exp_dev_reg)
                begin
                    out_status_next = mrc_pkg::ST_DEVICE;
                end
                else if ({1'b0, fn} != exp_fun_reg)
                begin
                    out_status_next = mrc_pkg::ST_FUNCTION;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (hdr_reg[1][7])
                    begin
                        out_status_next = mrc_pkg::ST_EXCEPTION;
                        out_exc_next    = hdr_reg[2];
                    end
                    else if (fn == mrc_pkg::FN_READ_HOLD || fn == mrc_pkg::FN_READ_INPUT)
                    begin
                        if (nread != exp_cnt_reg || need_len > 10'(len_reg)
                            || nread > 7'(mrc_pkg::MAX_WORDS))
                        begin
                            out_status_next = mrc_pkg::ST_COUNT;
                        end
                        else
                        begin
                            out_status_next = mrc_pkg::ST_OK;
                            nwords_next     = nread;
                        end
                    end
                    else if (fn == mrc_pkg::FN_WRITE_ONE || fn == mrc_pkg::FN_WRITE_MANY)
                    begin
                        if (len_reg < LW'(8))
                        begin
                            out_status_next = mrc_pkg::ST_SHORT;
                        end
                        else if (w2 + 16'd1 == exp_addr_reg
                                 && ((fn == mrc_pkg::FN_WRITE_ONE && w4 == exp_val_reg)
                                     || (fn == mrc_pkg::FN_WRITE_MANY
                                         && w4 == {9'd0, exp_cnt_reg})))
                        begin
                            out_status_next = mrc_pkg::ST_OK;
                        end
                        else
                        begin
                            out_status_next = mrc_pkg::ST_ECHO;
                        end
                    end
                    else
                    begin
                        out_status_next = mrc_pkg::ST_UNHANDLED;
                    end
                end
                // timeout can follow only while the request stays pending
                out_last_next = !(pend_next && age_reg >= tmo_cfg_reg) && (nwords_next == 7'd0);
            end

            // fetch one big-endian register word
            mrc_pkg::S_WORD:
            begin
                mem_rd_addr = ptr_reg;
                wcnt_next   = wcnt_reg + 2'd1;
                if (wcnt_reg == 2'd0)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (wcnt_reg == 2'd1)
                begin
                    hi_next  = mem_rd_data;
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    out_kind_next   = mrc_pkg::KIND_WORD;
                    out_status_next = mrc_pkg::ST_OK;
                    out_exc_next    = 8'd0;
                    out_word_next   = {hi_reg, mem_rd_data};
                    out_idx_next    = widx_reg;
                    out_last_next   = (widx_reg + 7'd1 == nwords_reg);
                    wcnt_next       = 2'd0;
                    state_next      = mrc_pkg::S_OUT;
                end
            end

            // hold the result until it is taken
            mrc_pkg::S_OUT:
            begin
                if (m_xfer)
                begin
                    if (out_kind_reg == mrc_pkg::KIND_TIMEOUT)
                    begin
                        state_next = mrc_pkg::S_IDLE;
                    end
                    else if (out_kind_reg == mrc_pkg::KIND_WORD)
                    begin
                        widx_next = widx_reg + 7'd1;
                        if (widx_reg + 7'd1 < nwords_reg)
                        begin
                            state_next = mrc_pkg::S_WORD;
                        end
                        else
                        begin
                            state_next = mrc_pkg::S_TMO;
                        end
                    end
                    else if (nwords_reg != 7'd0)
                    begin
                        wcnt_next  = 2'd0;
                        state_next = mrc_pkg::S_WORD;
                    end
                    else
                    begin
                        state_next = mrc_pkg::S_TMO;
                    end
                end
            end

            // reply timer check after any verdict and on a tick without one
            mrc_pkg::S_TMO:
            begin
                state_next = mrc_pkg::S_IDLE;
                if (pend_reg)
                begin
                    if (age_reg >= tmo_cfg_reg)
                    begin
                        pend_next       = 1'b0;
                        tmo_tot_next    = tmo_tot_reg + 32'd1;
                        out_kind_next   = mrc_pkg::KIND_TIMEOUT;
                        out_status_next = mrc_pkg::ST_OK;
                        out_fn_next     = 7'd0;
                        out_exc_next    = 8'd0;
                        out_word_next   = 16'd0;
                        out_idx_next    = 7'd0;
                        out_last_next   = 1'b1;
                        state_next      = mrc_pkg::S_OUT;
                    end
                    else
                    begin
                        age_next = age_reg + 16'd1;
                    end
                end
            end

            default:
            begin
                state_next = mrc_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mrc_pkg::S_IDLE;
            tmo_cfg_reg  <= mrc_pkg::REPLY_TIMEOUT_RST;
            gap_cfg_reg  <= mrc_pkg::FRAME_GAP_RST;
            len_reg      <= '0;
            seen_reg     <= 1'b0;
            silence_reg  <= 8'd0;
            pend_reg     <= 1'b0;
            exp_dev_reg  <= 8'd0;
            exp_fun_reg  <= 8'd0;
            exp_addr_reg <= 16'd0;
            exp_cnt_reg  <= 7'd0;
            exp_val_reg  <= 16'd0;
            age_reg      <= 16'd0;
            tmo_tot_reg  <= 32'd0;
            crc_tot_reg  <= 32'd0;
            bit_cnt_reg  <= 3'd0;
            hdr_cnt_reg  <= 3'd0;
            wcnt_reg     <= 2'd0;
            nwords_reg   <= 7'd0;
            widx_reg     <= 7'd0;
        end
        else
        begin
            state_reg    <= state_next;
            tmo_cfg_reg  <= tmo_cfg_next;
            gap_cfg_reg  <= gap_cfg_next;
            len_reg      <= len_next;
            seen_reg     <= seen_next;
            silence_reg  <= silence_next;
            pend_reg     <= pend_next;
            exp_dev_reg  <= exp_dev_next;
            exp_fun_reg  <= exp_fun_next;
            exp_addr_reg <= exp_addr_next;
            exp_cnt_reg  <= exp_cnt_next;
            exp_val_reg  <= exp_val_next;
            age_reg      <= age_next;
            tmo_tot_reg  <= tmo_tot_next;
            crc_tot_reg  <= crc_tot_next;
            bit_cnt_reg  <= bit_cnt_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            wcnt_reg     <= wcnt_next;
            nwords_reg   <= nwords_next;
            widx_reg     <= widx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        hi_reg         <= hi_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_fn_reg     <= out_fn_next;
        out_exc_reg    <= out_exc_next;
        out_word_reg   <= out_word_next;
        out_idx_reg    <= out_idx_next;
        out_last_reg   <= out_last_next;
        if (hdr_we)
        begin
            hdr_reg[hdr_sel] <= mem_rd_data;
        end
    end

    // ports
    assign s_tready = (state_reg == mrc_pkg::S_IDLE);
    assign m_tvalid = (state_reg == mrc_pkg::S_OUT);
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, crc_tot_reg, tmo_tot_reg, out_idx_reg, out_word_reg,
                       out_exc_reg, out_fn_reg, out_status_reg};

    // input and output never both open
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output open together");

    // crc error total moves by one at most, only on a crc verdict
    a_crc_total: assert property (@(posedge clk) disable iff (!rst_n)
        (crc_tot_reg != $past(crc_tot_reg)) |->
            (crc_tot_reg == $past(crc_tot_reg) + 32'd1
             && $past(state_reg) == mrc_pkg::S_JUDGE))
        else $error("crc error total moved unexpectedly");

    // stored length never exceeds the buffer
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(RX_BYTES))
        else $error("receive length beyond buffer");

    // a timeout result always ends the request
    a_tmo_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == mrc_pkg::KIND_TIMEOUT) |-> (!pend_reg && m_tlast))
        else $error("timeout result with request still pending");

endmodule

[rtl/core/mrc_crc_unit.sv]
// ----------------------------------------------------------------------------
// mrc_crc_unit
// Bit-serial Modbus CRC-16: one byte is mixed in, then one shift per cycle.
// ----------------------------------------------------------------------------
module mrc_crc_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  mrc_pkg::crc_ctrl_t ctrl,
    output logic              crc_zero
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // clear, byte mix or one reflected shift step
    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.clear)
        begin
            crc_next = mrc_pkg::CRC_INIT;
        end
        else if (ctrl.mix)
        begin
            crc_next = crc_reg ^ {8'd0, ctrl.data};
        end
        else if (ctrl.step)
        begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ mrc_pkg::CRC_POLY) : (crc_reg >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= mrc_pkg::CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc_zero = (crc_reg == 16'd0);

endmodule

[rtl/core/mrc_rx_mem.sv]
// ----------------------------------------------------------------------------
// mrc_rx_mem
// Receive byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrc_rx_mem
#(
    parameter int DEPTH = mrc_pkg::RX_BYTES_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus RTU master reply checker core.
// ----------------------------------------------------------------------------
// Requests, received bytes and 1 ms ticks are streamed into the core. Most
// replies are well-formed frames with a correct CRC; the rest are corrupted,
// truncated or foreign. A software copy of the checker predicts every result
// and a scoreboard compares the results field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    // one predicted or observed result
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  status;
        logic [6:0]  func;
        logic [7:0]  exc;
        logic [15:0] word;
        logic [6:0]  idx;
        logic        last;
        logic [31:0] tmo_total;
        logic [31:0] crc_total;
    } reply_t;

    // scoreboard of expected results
    class reply_board;
        reply_t pending_q[$];
        int     errors;

        function void note(reply_t r);
            pending_q.push_back(r);
        endfunction

        function void check(reply_t got);
            reply_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: got %p", $time, got);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t mismatch: expected %p actual %p", $time, want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [111:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    modbus_rtu_master_reply_checker_core dut (.*);

    // predictor state
    logic [7:0]  buf_mem [64];
    int          buf_len;
    logic [15:0] run_crc;
    bit          byte_seen;
    int          quiet_ms;
    bit          req_open;
    logic [7:0]  req_dev;
    logic [7:0]  req_fn;
    logic [15:0] req_addr;
    logic [6:0]  req_cnt;
    logic [15:0] req_val;
    int          age_ms;
    logic [31:0] tmo_count;
    logic [31:0] crc_count;
    int          timeout_cfg;
    int          gap_cfg;

    reply_board  board;
    bit          hold_off;
    longint      cycles;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
        c = c ^ b;
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ mrc_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [15:0] buf_word(int p);
        return {buf_mem[p % 64], buf_mem[(p + 1) % 64]};
    endfunction

    function automatic void push_result(logic [1:0] k, logic [3:0] st, logic [6:0] f,
                                        logic [7:0] e, logic [15:0] w, logic [6:0] i);
        reply_t r;
        r = '{k, st, f, e, w, i, 1'b0, tmo_count, crc_count};
        board.note(r);
    endfunction

    // frame verdict on the stored bytes
    function automatic void judge_frame();
        logic [6:0] fn;
        int n;
        if (buf_len <= 4)
        begin
            push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_SHORT, 0, 0, 0, 0);
            return;
        end
        if (run_crc != 0)
        begin
            crc_count++;
            push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_CRC, 0, 0, 0, 0);
            return;
        end
        fn = buf_mem[1][6:0];
        if (buf_mem[0] != req_dev)
        begin
            push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_DEVICE, fn, 0, 0, 0);
            return;
        end
        if ({1'b0, fn} != req_fn)
        begin
            push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_FUNCTION, fn, 0, 0, 0);
            return;
        end
        req_open = 0;
        if (buf_mem[1][7])
            push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_EXCEPTION, fn, buf_mem[2], 0, 0);
        else if (fn == mrc_pkg::FN_READ_HOLD || fn == mrc_pkg::FN_READ_INPUT)
        begin
            n = buf_mem[2] >> 1;
            if (n != req_cnt || 5 + 2 * n > buf_len || n > mrc_pkg::MAX_WORDS)
                push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_COUNT, fn, 0, 0, 0);
            else
            begin
                push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_OK, fn, 0, 0, 0);
                for (int i = 0; i < n; i++)
                    push_result(mrc_pkg::KIND_WORD, mrc_pkg::ST_OK, fn, 0,
                                buf_word(3 + 2 * i), i[6:0]);
            end
        end
        else if (fn == mrc_pkg::FN_WRITE_ONE || fn == mrc_pkg::FN_WRITE_MANY)
        begin
            if (buf_len < 8)
                push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_SHORT, fn, 0, 0, 0);
            else if (16'(buf_word(2) + 1) == req_addr &&
                     buf_word(4) == (fn == mrc_pkg::FN_WRITE_ONE ? req_val
                                                                 : {9'd0, req_cnt}))
                push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_OK, fn, 0, 0, 0);
            else
                push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_ECHO, fn, 0, 0, 0);
        end
        else
            push_result(mrc_pkg::KIND_STATUS, mrc_pkg::ST_UNHANDLED, fn, 0, 0, 0);
    endfunction

    function automatic void clear_frame();
        buf_len = 0;
        run_crc = mrc_pkg::CRC_INIT;
        byte_seen = 0;
        quiet_ms = 0;
    endfunction

    // advance the predictor by one accepted item
    function automatic void predict(logic [1:0] op, logic [63:0] d);
        int queued_cnt;
        queued_cnt = board.pending_q.size();
        if (op == mrc_pkg::OP_START)
        begin
            if (!(d[15:8] == 16 && d[38:32] >= mrc_pkg::WRITE_MANY_LIMIT))
            begin
                req_dev = d[7:0];
                req_fn = d[15:8];
                req_addr = d[31:16];
                req_cnt = d[38:32];
                req_val = d[54:39];
                req_open = 1;
                age_ms = 0;
                clear_frame();
            end
        end
        else if (op == mrc_pkg::OP_BYTE)
        begin
            if (buf_len < 64)
            begin
                buf_mem[buf_len] = d[62:55];
                run_crc = crc_next(run_crc, d[62:55]);
                buf_len++;
            end
            byte_seen = 1;
            quiet_ms = 0;
        end
        else if (op == mrc_pkg::OP_TICK)
        begin
            if (byte_seen)
            begin
                if (quiet_ms >= gap_cfg)
                begin
                    judge_frame();
                    clear_frame();
                end
                else
                    quiet_ms++;
            end
            if (req_open)
            begin
                if (age_ms >= timeout_cfg)
                begin
                    req_open = 0;
                    tmo_count++;
                    push_result(mrc_pkg::KIND_TIMEOUT, mrc_pkg::ST_OK, 0, 0, 0, 0);
                end
                else
                    age_ms++;
            end
            if (board.pending_q.size() > queued_cnt)
                board.pending_q[$].last = 1'b1;
        end
    endfunction

    // one item on the slave side, with a random gap first
    task automatic send(logic [1:0] op, logic [63:0] d);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict(op, d);
    endtask

    task automatic start_req(logic [7:0] dv, logic [7:0] fn, logic [15:0] a,
                             logic [6:0] c, logic [15:0] v);
        send(mrc_pkg::OP_START, {1'b0, 8'd0, v, c, a, fn, dv});
    endtask

    task automatic rx(logic [7:0] b);
        send(mrc_pkg::OP_BYTE, {1'b0, b, 55'd0});
    endtask

    task automatic ticks(int n);
        repeat (n) send(mrc_pkg::OP_TICK, 64'd0);
    endtask

    // send bytes followed by their crc, optionally corrupting it
    task automatic rx_frame(logic [7:0] f[$], bit bad_crc);
        logic [15:0] c;
        c = mrc_pkg::CRC_INIT;
        foreach (f[i])
        begin
            c = crc_next(c, f[i]);
            rx(f[i]);
        end
        if (bad_crc)
            c = c ^ 16'h0001 << $urandom_range(0, 15);
        rx(c[7:0]);
        rx(c[15:8]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == mrc_pkg::CFG_REPLY_TIMEOUT)
            timeout_cfg = val;
        else
            gap_cfg = val[7:0];
    endtask

    // one request and a reply built for it, mostly well formed
    task automatic transaction(bit small_timer);
        logic [7:0]  dv, fn, q[$];
        logic [15:0] a, v;
        logic [6:0]  c;
        int          pick, n;
        dv = 8'($urandom);
        pick = $urandom_range(0, 9);
        fn = 8'(pick < 4 ? 3 : pick < 6 ? 4 : pick < 8 ? 6 : pick < 9 ? 16 : $urandom);
        a = 16'($urandom);
        v = 16'($urandom);
        c = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 8));
        if (fn == 16 && $urandom_range(0, 5) == 0)
            c = 7'($urandom_range(118, 127));
        start_req(dv, fn, a, c, v);
        q = {dv, fn};
        if (fn == 3 || fn == 4)
        begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 30) : c;
            if ($urandom_range(0, 7) == 0)
                q[1] = fn | 8'h80;
            q.push_back(8'(2 * n + $urandom_range(0, 4) / 4));
            for (int i = 0; i < 2 * n && q.size() < 62; i++)
                q.push_back(8'($urandom));
        end
        else if (fn == 6 || fn == 16)
        begin
            q.push_back(8'((a - 1) >> 8));
            q.push_back(8'(a - 1));
            if (fn == 6)
                q = {q, v[15:8], v[7:0]};
            else
            begin
                q.push_back(8'd0);
                q.push_back({1'b0, c});
            end
            if ($urandom_range(0, 4) == 0)
                q[2 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            if ($urandom_range(0, 6) == 0)
                void'(q.pop_back());
        end
        else
            q.push_back(8'($urandom));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            q[0] = ~q[0];
        else if (pick == 1)
            q[1] = q[1] ^ 8'h01;
        else if (pick == 2)
            q = q[0:0];
        rx_frame(q, pick == 3);
        if (pick == 4)
            rx(8'($urandom));
        ticks(small_timer ? $urandom_range(1, 8) : gap_cfg + 2);
    endtask

    // receiver side: random stalls, plus one long hold-off
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check({m_tuser, m_tdata[3:0], m_tdata[10:4], m_tdata[18:11],
                         m_tdata[34:19], m_tdata[41:35], m_tlast,
                         m_tdata[73:42], m_tdata[105:74]});

    // cycle limit
    initial
    begin
        wait (cycles > 64'd2000000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        board = new();
        cycles = 0;
        hold_off = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = mrc_pkg::OP_START;
        cfg_we = 1'b0;
        cfg_index = mrc_pkg::CFG_REPLY_TIMEOUT;
        cfg_data = '0;
        timeout_cfg = mrc_pkg::REPLY_TIMEOUT_RST;
        gap_cfg = mrc_pkg::FRAME_GAP_RST;
        tmo_count = 0;
        crc_count = 0;
        req_open = 0;
        req_dev = 0;
        req_fn = 0;
        req_addr = 0;
        req_cnt = 0;
        req_val = 0;
        age_ms = 0;
        clear_frame();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: gap and timeout both set to 1
        write_cfg(mrc_pkg::CFG_FRAME_GAP, 16'd1);
        write_cfg(mrc_pkg::CFG_REPLY_TIMEOUT, 16'd1);
        ticks(1);
        rx(8'h00);
        ticks(2);
        start_req(8'hFF, 8'd3, 16'hFFFF, 7'd2, 16'hFFFF);
        rx_frame({8'hFF, 8'd3, 8'd4, 8'hFF, 8'h00, 8'h12, 8'h34}, 0);
        ticks(3);
        start_req(8'h00, 8'd16, 16'h0000, 7'd127, 16'h0000);
        start_req(8'h01, 8'd6, 16'h0001, 7'd0, 16'hA5A5);
        rx_frame({8'h01, 8'd6, 8'h00, 8'h00, 8'hA5, 8'hA5}, 0);
        ticks(3);
        start_req(8'h02, 8'd4, 16'h0010, 7'd1, 16'd0);
        rx_frame({8'h02, 8'h84, 8'h02}, 0);
        ticks(3);
        start_req(8'h07, 8'd99, 16'd5, 7'd1, 16'd0);
        rx_frame({8'h07, 8'd99, 8'h00}, 1);
        ticks(4);
        wait_drained();

        // buffer overflow and a zero timeout
        write_cfg(mrc_pkg::CFG_REPLY_TIMEOUT, 16'd0);
        write_cfg(mrc_pkg::CFG_FRAME_GAP, 16'd3);
        start_req(8'h05, 8'd3, 16'd1, 7'd29, 16'd0);
        repeat (70) rx(8'($urandom));
        ticks(5);
        wait_drained();

        // receiver holds off while ticks pile up results
        write_cfg(mrc_pkg::CFG_REPLY_TIMEOUT, 16'd65535);
        write_cfg(mrc_pkg::CFG_FRAME_GAP, 16'd3);
        hold_off = 1;
        repeat (3) transaction(0);
        wait_drained();

        // random phases under several settings
        for (int ph = 0; ph < 4; ph++)
        begin
            write_cfg(mrc_pkg::CFG_REPLY_TIMEOUT,
                      ph == 0 ? 16'd2 : 16'($urandom_range(1, 20)));
            write_cfg(mrc_pkg::CFG_FRAME_GAP, ph == 3 ? 16'd1 : 16'($urandom_range(1, 4)));
            repeat (2)
            begin
                if ($urandom_range(0, 6) == 0)
                    send(2'(mrc_pkg::OP_BYTE + $urandom_range(0, 2)), {$urandom, $urandom});
                transaction($urandom_range(0, 3) == 0);
            end
            wait_drained();
        end

        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/core/mrc_pkg.sv
rtl/core/mrc_crc_unit.sv
rtl/core/mrc_rx_mem.sv
rtl/core/modbus_rtu_master_reply_checker_core.sv
tb/testbench.sv
